[rtl/rect_line_parser_unit_defines.svh]
// Assertion macros shared by the rect line parser RTL.
// No dependencies; included by the modules that carry checks.
`ifndef RECT_LINE_PARSER_UNIT_DEFINES_SVH
`define RECT_LINE_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RLP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rect_line_parser: same-cycle check failed");
`define RLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rect_line_parser: next-cycle check failed");
`else
`define RLP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/rlp_pkg.sv]
// Shared types and constants for the rect line parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rlp_pkg;

   localparam int SCALE_BITS    = 16;
   localparam int SKIP_BITS     = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int OUT_BITS      = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SKIP_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_UP   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_DOWN = 2'd2;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [2:0] DIR_VALID = 3'h1;
   localparam logic [2:0] DIR_S     = 3'h2;
   localparam logic [2:0] DIR_E     = 3'h4;
   localparam logic [2:0] DIR_FAIL  = 3'h0;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_file;
   } rlp_req_type;

   typedef struct packed {
      logic [2:0]                 direction;
      logic signed [OUT_BITS-1:0] x_low;
      logic signed [OUT_BITS-1:0] y_low;
      logic signed [OUT_BITS-1:0] x_high;
      logic signed [OUT_BITS-1:0] y_high;
   } rlp_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SKIP,
      ST_DIGITS,
      ST_SPACE,
      ST_TRAIL,
      ST_DISCARD,
      ST_SCALE,
      ST_EMIT
   } rlp_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_SIGN,
      SC_DIV,
      SC_FIX,
      SC_DONE
   } rlp_sc_state_type;

   // controller -> datapath
   typedef struct packed {
      logic       field_start;
      logic       neg_set;
      logic       digit_en;
      logic       store_en;
      logic [1:0] store_idx;
      logic       scale_start;
      logic [1:0] scale_idx;
      logic       dir_s;
      logic       dir_e;
      logic       dir_clear;
      logic       out_load;
      logic       out_good;
   } rlp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scale_done;
   } rlp_stat_type;

endpackage

[rtl/rect_line_parser_unit.sv]
// Rect line parser top level: configuration registers, controller and datapath.
// Depends on rlp_pkg, rlp_ctrl, rlp_dpath.
`timescale 1ns / 1ps

// Parses a text stream, one byte or EOF mark per item, into records of four
// signed decimal coordinates plus 's'/'e' direction flags; each record first
// drops skip_count items. One item is taken per cycle while parsing. When the
// fourth number ends, input stalls while the shared multiply/divide unit scales
// the four coordinates in turn: a multiply by scale_up, then with scale_down > 1
// a restoring divide (one quotient bit per cycle) and a sign fix. A line-end or
// EOF item is also held while a previous result is still waiting at the output
// register.
module rect_line_parser_unit #(
   parameter int COORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rlp_pkg::rlp_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rlp_pkg::rlp_rsp_type              rsp_data,
   input  logic                              csr_wr_en,
   input  logic [rlp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rlp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import rlp_pkg::*;

   logic [SKIP_BITS-1:0]  skip_count_ff, skip_count_in;
   logic [SCALE_BITS-1:0] scale_up_ff, scale_up_in;
   logic [SCALE_BITS-1:0] scale_down_ff, scale_down_in;

   rlp_cmd_type  cmd;
   rlp_stat_type stat;

   always_comb begin
      skip_count_in = skip_count_ff;
      scale_up_in   = scale_up_ff;
      scale_down_in = scale_down_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SKIP_COUNT: skip_count_in = csr_wdata[SKIP_BITS-1:0];
            CSR_SCALE_UP:   scale_up_in   = csr_wdata[SCALE_BITS-1:0];
            CSR_SCALE_DOWN: scale_down_in = csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_count_ff <= '0;
         scale_up_ff   <= SCALE_BITS'(1);
         scale_down_ff <= SCALE_BITS'(1);
      end else begin
         skip_count_ff <= skip_count_in;
         scale_up_ff   <= scale_up_in;
         scale_down_ff <= scale_down_in;
      end
   end

   rlp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .skip_count (skip_count_ff),
      .cmd        (cmd),
      .stat       (stat)
   );

   rlp_dpath #(.COORD_BITS(COORD_BITS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .char_byte  (req_data.char_byte),
      .scale_up   (scale_up_ff),
      .scale_down (scale_down_ff),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/rlp_scale.sv]
// Scaling: multiply by scale_up, then signed truncating divide by scale_down, each
// if above 1. Restoring divider, one quotient bit per cycle. Depends on rlp_pkg.
`timescale 1ns / 1ps
`include "rect_line_parser_unit_defines.svh"

module rlp_scale #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     idx_in,
   input  logic [COORD_BITS-1:0]          value,
   input  logic [rlp_pkg::SCALE_BITS-1:0] scale_up,
   input  logic [rlp_pkg::SCALE_BITS-1:0] scale_down,
   output logic                           done,
   output logic [1:0]                     idx_out,
   output logic [COORD_BITS-1:0]          result
);
   import rlp_pkg::*;

   localparam int CNT_BITS  = $clog2(COORD_BITS);
   localparam int PROD_BITS = COORD_BITS + SCALE_BITS;

   rlp_sc_state_type sc_ff, sc_in;
   logic [COORD_BITS-1:0] val_ff, val_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [SCALE_BITS-1:0] rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [1:0]            idx_ff, idx_in_q;

   logic [PROD_BITS-1:0]  prod;
   logic [SCALE_BITS:0]   rem_sh;
   logic [SCALE_BITS+1:0] diff;
   logic                  take;
   logic                  last_bit;

   assign prod     = PROD_BITS'(val_ff) * PROD_BITS'(scale_up);
   assign rem_sh   = {rem_ff, quo_ff[COORD_BITS-1]};
   assign diff     = {1'b0, rem_sh} - {2'b00, scale_down};
   assign take     = !diff[SCALE_BITS+1];
   assign last_bit = (cnt_ff == CNT_BITS'(COORD_BITS - 1));

   // next state; a new start may arrive in the done cycle
   always_comb begin
      sc_in = sc_ff;
      unique case (sc_ff)
         SC_IDLE: if (start) sc_in = SC_MUL;
         SC_MUL:  sc_in = SC_SIGN;
         SC_SIGN: sc_in = (scale_down > SCALE_BITS'(1)) ? SC_DIV : SC_DONE;
         SC_DIV:  if (last_bit) sc_in = SC_FIX;
         SC_FIX:  sc_in = SC_DONE;
         SC_DONE: sc_in = start ? SC_MUL : SC_IDLE;
         default: sc_in = SC_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done    = (sc_ff == SC_DONE);
      idx_out = idx_ff;
      result  = val_ff;
   end

   // datapath registers
   always_comb begin
      val_in   = val_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      idx_in_q = idx_ff;
      case (sc_ff)
         SC_IDLE, SC_DONE: begin
            if (start) begin
               val_in   = value;
               idx_in_q = idx_in;
            end
         end
         SC_MUL: begin
            if (scale_up > SCALE_BITS'(1)) val_in = prod[COORD_BITS-1:0];
         end
         SC_SIGN: begin
            neg_in = val_ff[COORD_BITS-1];
            quo_in = val_ff[COORD_BITS-1] ? (~val_ff + COORD_BITS'(1)) : val_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         SC_DIV: begin
            rem_in = take ? diff[SCALE_BITS-1:0] : rem_sh[SCALE_BITS-1:0];
            quo_in = {quo_ff[COORD_BITS-2:0], take};
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
         SC_FIX: begin
            val_in = neg_ff ? (~quo_ff + COORD_BITS'(1)) : quo_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= SC_IDLE;
      end else begin
         sc_ff <= sc_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in_q;
   end

   `RLP_ASSERT_IMPL(a_start_when_idle, clock, reset, start, (sc_ff == SC_IDLE) || (sc_ff == SC_DONE))
   `RLP_ASSERT_NEXT(a_done_single, clock, reset, done, !done)
   `RLP_ASSERT_IMPL(a_rem_below_div, clock, reset, sc_ff == SC_DIV, rem_ff < scale_down)

endmodule

[rtl/rlp_dpath.sv]
// Datapath: digit accumulator, coordinate store, direction bits, result register.
// Depends on rlp_pkg and rlp_scale.
`timescale 1ns / 1ps

module rlp_dpath #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rlp_pkg::rlp_cmd_type           cmd,
   input  logic [7:0]                     char_byte,
   input  logic [rlp_pkg::SCALE_BITS-1:0] scale_up,
   input  logic [rlp_pkg::SCALE_BITS-1:0] scale_down,
   output rlp_pkg::rlp_stat_type          stat,
   output rlp_pkg::rlp_rsp_type           rsp_data
);
   import rlp_pkg::*;

   logic [COORD_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [1:0]            dir_ff, dir_in;
   logic [COORD_BITS-1:0] coord_ff [4];
   rlp_rsp_type           rsp_ff, rsp_in;

   logic [COORD_BITS-1:0] base_acc;
   logic                  base_neg;
   logic [3:0]            dval;
   logic [COORD_BITS-1:0] acc_next;
   logic [COORD_BITS-1:0] store_val;

   logic                  sc_done;
   logic [1:0]            sc_idx;
   logic [COORD_BITS-1:0] sc_result;

   rlp_scale #(.COORD_BITS(COORD_BITS)) u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.scale_start),
      .idx_in     (cmd.scale_idx),
      .value      (coord_ff[cmd.scale_idx]),
      .scale_up   (scale_up),
      .scale_down (scale_down),
      .done       (sc_done),
      .idx_out    (sc_idx),
      .result     (sc_result)
   );

   assign stat.scale_done = sc_done;
   assign rsp_data        = rsp_ff;

   always_comb begin
      base_acc  = cmd.field_start ? '0 : acc_ff;
      base_neg  = cmd.field_start ? 1'b0 : neg_ff;
      dval      = 4'(char_byte - CH_ZERO);
      // acc * 10 + digit
      acc_next  = (base_acc << 3) + (base_acc << 1) + COORD_BITS'(dval);
      store_val = base_neg ? (~base_acc + COORD_BITS'(1)) : base_acc;
   end

   always_comb begin
      acc_in = acc_ff;
      neg_in = neg_ff;
      if (cmd.store_en) begin
         acc_in = '0;
         neg_in = 1'b0;
      end else if (cmd.digit_en) begin
         acc_in = acc_next;
         neg_in = base_neg;
      end else if (cmd.field_start) begin
         acc_in = '0;
         neg_in = cmd.neg_set;
      end
   end

   always_comb begin
      if (cmd.dir_clear) dir_in = 2'b00;
      else               dir_in = dir_ff | {cmd.dir_e, cmd.dir_s};
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         if (cmd.out_good) begin
            rsp_in.direction = DIR_VALID | (dir_ff[0] ? DIR_S : DIR_FAIL)
                                         | (dir_ff[1] ? DIR_E : DIR_FAIL);
            rsp_in.x_low  = OUT_BITS'($signed(coord_ff[0]));
            rsp_in.y_low  = OUT_BITS'($signed(coord_ff[1]));
            rsp_in.x_high = OUT_BITS'($signed(coord_ff[2]));
            rsp_in.y_high = OUT_BITS'($signed(coord_ff[3]));
         end else begin
            rsp_in.direction = DIR_FAIL;
            rsp_in.x_low     = '0;
            rsp_in.y_low     = '0;
            rsp_in.x_high    = '0;
            rsp_in.y_high    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         neg_ff <= 1'b0;
         dir_ff <= 2'b00;
      end else begin
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         dir_ff <= dir_in;
      end
   end

   // store writes and scaler write-back never land in the same cycle
   always_ff @(posedge clock) begin
      if (cmd.store_en) coord_ff[cmd.store_idx] <= store_val;
      if (sc_done)      coord_ff[sc_idx]        <= sc_result;
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/rlp_ctrl.sv]
// Record controller: phase sequencing, skip count, field index, result handshake.
// Depends on rlp_pkg; drives the datapath through rlp_cmd_type.
`timescale 1ns / 1ps
`include "rect_line_parser_unit_defines.svh"

module rlp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rlp_pkg::rlp_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [rlp_pkg::SKIP_BITS-1:0] skip_count,
   output rlp_pkg::rlp_cmd_type          cmd,
   input  rlp_pkg::rlp_stat_type         stat
);
   import rlp_pkg::*;

   rlp_state_type        state_ff, state_in;
   logic [1:0]           field_ff, field_in;
   logic [SKIP_BITS-1:0] skip_left_ff, skip_left_in;
   logic                 fin_after_ff, fin_after_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 eof;
   logic [7:0]           ch;
   logic                 is_dig, is_sp, is_minus, is_s, is_e, line_end;
   logic                 out_free, accept;
   logic                 skip_phase, skipping;
   logic [SKIP_BITS-1:0] eff_skip;
   logic                 enter_field, in_digits, field_end, last_field;
   logic [1:0]           cur_field;

   // byte classes and phase decode
   always_comb begin
      eof      = req_data.end_of_file;
      ch       = req_data.char_byte;
      is_dig   = !eof && (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_sp    = !eof && ((ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR)));
      is_minus = !eof && (ch == CH_MINUS);
      is_s     = !eof && (ch == CH_S);
      is_e     = !eof && (ch == CH_E);
      line_end = eof || (ch == CH_NL);

      out_free = !rsp_valid_ff || !rsp_stall;
      // only a line end or EOF item can finish a record from the input side
      req_stall = (state_ff == ST_SCALE) || (state_ff == ST_EMIT)
                  || (!out_free && line_end);
      accept = req_valid && !req_stall;

      skip_phase  = (state_ff == ST_IDLE) || (state_ff == ST_SKIP);
      eff_skip    = (state_ff == ST_IDLE) ? skip_count : skip_left_ff;
      skipping    = skip_phase && (eff_skip != '0);
      enter_field = (skip_phase && (eff_skip == '0)) || ((state_ff == ST_SPACE) && !is_sp);
      if (skip_phase)                 cur_field = 2'd0;
      else if (state_ff == ST_SPACE)  cur_field = field_ff + 2'd1;
      else                            cur_field = field_ff;
      in_digits  = (state_ff == ST_DIGITS) || (enter_field && !is_minus);
      field_end  = in_digits && !is_dig;
      last_field = (cur_field == 2'd3);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_SKIP, ST_DIGITS, ST_SPACE: begin
            if (accept) begin
               if (skipping)                             state_in = ST_SKIP;
               else if ((state_ff == ST_SPACE) && is_sp) state_in = ST_SPACE;
               else if (!field_end)                      state_in = ST_DIGITS;
               else if (last_field)                      state_in = ST_SCALE;
               else if (is_sp)                           state_in = ST_SPACE;
               else if (eof)                             state_in = ST_IDLE;
               else                                      state_in = ST_DISCARD;
            end
         end
         ST_TRAIL, ST_DISCARD: begin
            if (accept && line_end) state_in = ST_IDLE;
         end
         ST_SCALE: begin
            if (stat.scale_done && (field_ff == 2'd3))
               state_in = fin_after_ff ? ST_EMIT : ST_TRAIL;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd           = '0;
      cmd.store_idx = cur_field;
      cmd.scale_idx = field_ff + 2'd1;
      unique case (state_ff) inside
         ST_IDLE, ST_SKIP, ST_DIGITS, ST_SPACE: begin
            if (accept) begin
               cmd.field_start = enter_field;
               cmd.neg_set     = enter_field && is_minus;
               cmd.digit_en    = in_digits && is_dig;
               cmd.store_en    = field_end;
               if (field_end && last_field) begin
                  cmd.scale_start = 1'b1;
                  cmd.scale_idx   = 2'd0;
               end
               if (field_end && !last_field && eof) begin
                  cmd.out_load  = 1'b1;
                  cmd.dir_clear = 1'b1;
               end
            end
         end
         ST_TRAIL: begin
            if (accept) begin
               if (line_end) begin
                  cmd.out_load  = 1'b1;
                  cmd.out_good  = 1'b1;
                  cmd.dir_clear = 1'b1;
               end else begin
                  cmd.dir_s = is_s;
                  cmd.dir_e = is_e;
               end
            end
         end
         ST_DISCARD: begin
            if (accept && line_end) begin
               cmd.out_load  = 1'b1;
               cmd.dir_clear = 1'b1;
            end
         end
         ST_SCALE: begin
            cmd.scale_start = stat.scale_done && (field_ff != 2'd3);
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_good  = 1'b1;
               cmd.dir_clear = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // counters and flags
   always_comb begin
      field_in     = field_ff;
      skip_left_in = skip_left_ff;
      fin_after_in = fin_after_ff;
      if (accept && skipping) skip_left_in = eff_skip - SKIP_BITS'(1);
      if (accept && enter_field) field_in = cur_field;
      if (accept && field_end && last_field) begin
         field_in     = 2'd0;   // reused as the scaling index
         fin_after_in = line_end;
      end
      if (stat.scale_done) field_in = field_ff + 2'd1;
      if (cmd.out_load) field_in = 2'd0;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         field_ff     <= 2'd0;
         skip_left_ff <= '0;
         fin_after_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         field_ff     <= field_in;
         skip_left_ff <= skip_left_in;
         fin_after_ff <= fin_after_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RLP_ASSERT_IMPL(a_done_in_scale, clock, reset, stat.scale_done, state_ff == ST_SCALE)
   `RLP_ASSERT_IMPL(a_load_slot_free, clock, reset, cmd.out_load, out_free)
   `RLP_ASSERT_IMPL(a_emit_line_end, clock, reset, state_ff == ST_EMIT, fin_after_ff)
   `RLP_ASSERT_IMPL(a_idle_field_zero, clock, reset, state_ff == ST_IDLE, field_ff == 2'd0)

endmodule

[tb/sv/rect_line_parser_unit_tb.sv]
// Self-checking testbench for rect_line_parser_unit: byte-stream stimulus with a
// built-in parser image that predicts every line result. Depends on rlp_pkg and the RTL.
`timescale 1ns / 1ps

module rect_line_parser_unit_tb;
   import rlp_pkg::*;

   localparam int ITEM_TARGET  = 1650;
   localparam int DRAIN_CYCLES = 300;   // covers four scale passes plus output
   localparam int HOLD_CYCLES  = 600;
   localparam int QUIET_LIMIT  = 4000;  // longest legal stretch with no item moving
   localparam logic [7:0] CH_X = 8'h78;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rlp_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rlp_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_SKIP_COUNT;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // parser image: registers and per-record state
   logic [7:0]    skip_cfg;
   logic [15:0]   up_cfg;
   logic [15:0]   down_cfg;
   rlp_state_type parse_phase;
   logic [1:0]    field_idx;
   logic [7:0]    skip_left;
   logic [31:0]   acc;
   logic          acc_neg;
   logic [31:0]   coord [4];
   logic [1:0]    dir_bits;

   rlp_rsp_type expected_lines [$];
   int error_count = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   rect_line_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void clear_record();
      parse_phase = ST_IDLE;
      field_idx = '0;
      skip_left = '0;
      acc = '0;
      acc_neg = 1'b0;
      dir_bits = '0;
      for (int i = 0; i < 4; i++) coord[i] = '0;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [31:0] scale_coord(logic [31:0] v);
      logic [31:0] p;
      logic [31:0] mag;
      logic [31:0] q;
      p = v;
      if (up_cfg > 1) p = p * up_cfg;
      // divide the magnitude so the quotient truncates toward zero
      if (down_cfg > 1) begin
         mag = p[31] ? -p : p;
         q = mag / down_cfg;
         p = p[31] ? -q : q;
      end
      return p;
   endfunction

   function automatic rlp_rsp_type close_line(bit good);
      rlp_rsp_type r;
      r = '0;
      if (good) begin
         r.direction = DIR_VALID;
         if (dir_bits[0]) r.direction = r.direction | DIR_S;
         if (dir_bits[1]) r.direction = r.direction | DIR_E;
         r.x_low  = coord[0];
         r.y_low  = coord[1];
         r.x_high = coord[2];
         r.y_high = coord[3];
      end else begin
         r.direction = DIR_FAIL;
      end
      clear_record();
      return r;
   endfunction

   function automatic bit digit_or_end(logic [7:0] c, bit eof, output rlp_rsp_type r);
      r = '0;
      if (!eof && c >= CH_ZERO && c <= CH_NINE) begin
         acc = acc * 32'd10 + 32'(c - CH_ZERO);
         return 1'b0;
      end
      coord[field_idx] = acc_neg ? -acc : acc;
      acc = '0;
      acc_neg = 1'b0;
      if (field_idx != 2'd3) begin
         if (!eof && is_blank(c)) begin
            parse_phase = ST_SPACE;
            return 1'b0;
         end
         if (eof) begin
            r = close_line(1'b0);
            return 1'b1;
         end
         parse_phase = ST_DISCARD;
         return 1'b0;
      end
      // scale registers are taken as the fourth number ends
      for (int i = 0; i < 4; i++) coord[i] = scale_coord(coord[i]);
      if (eof || c == CH_NL) begin
         r = close_line(1'b1);
         return 1'b1;
      end
      parse_phase = ST_TRAIL;
      return 1'b0;
   endfunction

   function automatic bit open_field(logic [7:0] c, bit eof, output rlp_rsp_type r);
      r = '0;
      parse_phase = ST_DIGITS;
      acc = '0;
      if (!eof && c == CH_MINUS) begin
         acc_neg = 1'b1;
         return 1'b0;
      end
      acc_neg = 1'b0;
      return digit_or_end(c, eof, r);
   endfunction

   function automatic bit advance_parser(logic [7:0] c, bit eof, output rlp_rsp_type r);
      r = '0;
      if (parse_phase == ST_IDLE || parse_phase > ST_DISCARD) begin
         skip_left = skip_cfg;
         parse_phase = ST_SKIP;
      end
      case (parse_phase)
         ST_SKIP: begin
            if (skip_left != 0) begin
               skip_left--;
               return 1'b0;
            end
            field_idx = '0;
            return open_field(c, eof, r);
         end
         ST_DIGITS: return digit_or_end(c, eof, r);
         ST_SPACE: begin
            if (!eof && is_blank(c)) return 1'b0;
            field_idx++;
            return open_field(c, eof, r);
         end
         ST_TRAIL: begin
            if (eof || c == CH_NL) begin
               r = close_line(1'b1);
               return 1'b1;
            end
            if (c == CH_S) dir_bits[0] = 1'b1;
            else if (c == CH_E) dir_bits[1] = 1'b1;
            return 1'b0;
         end
         default: begin
            if (eof || c == CH_NL) begin
               r = close_line(1'b0);
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 9);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // handshakes are sampled at the falling edge; they complete at the next rise
   always @(negedge clock) begin
      rlp_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lines.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none actual %h", $time, rsp_data);
         end else begin
            want = expected_lines.pop_front();
            check_field("direction", 32'(want.direction), 32'(rsp_data.direction));
            check_field("x_low", want.x_low, rsp_data.x_low);
            check_field("y_low", want.y_low, rsp_data.y_low);
            check_field("x_high", want.x_high, rsp_data.x_high);
            check_field("y_high", want.y_high, rsp_data.y_high);
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("rect_line_parser_unit regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- input side

   task automatic send_item(logic [7:0] c, bit eof);
      rlp_req_type item;
      rlp_rsp_type line;
      item.char_byte = c;
      item.end_of_file = eof;
      while (!calm && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
      items_sent++;
      if (advance_parser(c, eof, line)) expected_lines.push_back(line);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_eof();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_any();
      if ($urandom_range(0, 99) < 12) send_eof();
      else send_item(8'($urandom_range(0, 255)), 1'b0);
   endtask

   function automatic logic [7:0] pick_blank();
      if ($urandom_range(0, 1) == 0) return CH_SPACE;
      return CH_TAB + 8'($urandom_range(0, 4));
   endfunction

   function automatic logic [7:0] pick_tail_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return CH_S;
      if (roll < 55) return CH_E;
      if (roll < 70) return CH_SPACE;
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly well-formed lines with random content; some noise and broken fields
   task automatic send_record();
      int roll;
      int n_digits;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(3, 12)) send_any();
         return;
      end
      repeat (skip_cfg) send_any();
      for (int f = 0; f < 4; f++) begin
         if ($urandom_range(0, 99) < 35) send_item(CH_MINUS, 1'b0);
         roll = $urandom_range(0, 99);
         if (roll < 5) n_digits = 0;
         else if (roll < 80) n_digits = $urandom_range(1, 4);
         else if (roll < 95) n_digits = $urandom_range(5, 10);
         else n_digits = $urandom_range(11, 14);
         repeat (n_digits) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         roll = $urandom_range(0, 99);
         if (f < 3) begin
            if (roll < 90) repeat ($urandom_range(1, 3)) send_item(pick_blank(), 1'b0);
            else send_any();
         end else if (roll < 35) begin
            send_item(CH_NL, 1'b0);
         end else if (roll < 43) begin
            send_eof();
         end else begin
            repeat ($urandom_range(1, 6)) send_item(pick_tail_byte(), 1'b0);
            if ($urandom_range(0, 99) < 90) send_item(CH_NL, 1'b0);
            else send_eof();
         end
      end
   endtask

   // drive bytes until the open record has ended in the image
   task automatic close_record();
      while (parse_phase != ST_IDLE) begin
         if (parse_phase == ST_TRAIL || parse_phase == ST_DISCARD) send_item(CH_NL, 1'b0);
         else send_item(CH_X, 1'b0);
      end
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] skip, logic [15:0] up, logic [15:0] down);
      close_record();
      drain_block();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SKIP_COUNT;
      csr_wdata <= CSR_DATA_BITS'(skip);
      @(posedge clock);
      skip_cfg = skip;
      csr_index <= CSR_SCALE_UP;
      csr_wdata <= up;
      @(posedge clock);
      up_cfg = up;
      csr_index <= CSR_SCALE_DOWN;
      csr_wdata <= down;
      @(posedge clock);
      down_cfg = down;
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      send_text("-9 0\t1 2 se");      // trailing flags, line ended by EOF
      send_eof();
      send_text(" 7x\n");             // empty first number, bad terminator
      send_text("1 2 3 ");            // EOF where the fourth number starts
      send_eof();
      send_text("5");                 // EOF as terminator fails at once
      send_eof();
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(CH_NL, 1'b0);
   endtask

   task automatic extreme_phase(logic [7:0] skip, logic [15:0] up, logic [15:0] down,
                                int n_records);
      set_config(skip, up, down);
      send_text("-2147483648 4294967299\t99999999999 -\n");
      repeat (n_records) send_record();
   endtask

   task automatic test_register_extremes();
      extreme_phase(8'd0, 16'hFFFF, 16'd0, 3);
      extreme_phase(8'hFF, 16'd0, 16'hFFFF, 1);
      extreme_phase(8'd1, 16'd2, 16'hFFFF, 3);
      extreme_phase(8'd0, 16'd1, 16'd2, 3);
      extreme_phase(8'd0, 16'hFFFF, 16'hFFFF, 3);
   endtask

   // result side holds off while lines keep coming, so the input backs up
   task automatic test_output_holdoff();
      set_config(8'd0, 16'd3, 16'd2);
      calm = 1'b1;
      hold_request = 1'b1;
      repeat (6) send_record();
      calm = 1'b0;
   endtask

   task automatic test_no_idle_stretch();
      set_config(8'd2, 16'd10, 16'd0);
      calm = 1'b1;
      repeat (10) send_record();
      calm = 1'b0;
   endtask

   function automatic logic [15:0] pick_scale();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return '0;
      if (roll < 35) return 16'd1;
      if (roll < 75) return 16'($urandom_range(2, 20));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic test_random_records();
      logic [7:0] skip;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 70) skip = 8'($urandom_range(0, 3));
         else skip = 8'($urandom_range(4, 20));
         set_config(skip, pick_scale(), pick_scale());
         repeat ($urandom_range(6, 14)) send_record();
      end
   endtask

   initial begin
      skip_cfg = '0;
      up_cfg = 16'd1;
      down_cfg = 16'd1;
      clear_record();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_extremes();
      test_output_holdoff();
      test_no_idle_stretch();
      test_random_records();
      drain_block();
      if (error_count == 0 && expected_lines.size() == 0) begin
         $display("rect_line_parser_unit regression: pass");
      end else begin
         $display("rect_line_parser_unit regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/rlp_pkg.sv
rtl/rlp_scale.sv
rtl/rlp_dpath.sv
rtl/rlp_ctrl.sv
rtl/rect_line_parser_unit.sv
tb/sv/rect_line_parser_unit_tb.sv
